@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CSDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also applies during reset.
`define CSDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/csds_pkg.sv @@
`default_nettype none

package csds_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES = 16;

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;

  localparam int PHASE_DIV = 90;
  localparam int PH_HALF = PHASE_DIV / 2;
  localparam int PH_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int PH_A_W = ANGLE_FRAC_BITS + 2;
  localparam int PH_B_W = 7;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_MUL = (2 ** RECIP_SHIFT + PHASE_DIV - 1) / PHASE_DIV;

  localparam longint CORDIC_GAIN = 652032874;
  localparam int TABLE_LEN = 24;
  localparam int GUARD_SHIFT = 16;
  localparam int KEEP_BITS = 14;
  localparam int SPEED_MAX = 131071;
  localparam int SQRT_STEPS = 32;

  localparam logic [1:0] REG_SPEED_TOL = 2'd0;
  localparam logic [1:0] REG_ANGLE_TOL = 2'd1;
  localparam logic [15:0] SPEED_TOL_RST = 16'd3;
  localparam logic [15:0] ANGLE_TOL_RST = 16'd64;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic [PH_SHIFT-1:0] pfrac_tab_t [PHASE_DIV];

  function automatic pfrac_tab_t pfrac_build();
    pfrac_tab_t tab;
    for (int b = 0; b < PHASE_DIV; b++) begin
      tab[b] = PH_SHIFT'(((longint'(b) << PH_SHIFT) + PH_HALF) / PHASE_DIV);
    end
    return tab;
  endfunction

  localparam pfrac_tab_t PFRAC_TAB = pfrac_build();

  typedef struct packed {
    logic               spec;
    logic signed [17:0] spd;
    logic signed [17:0] ang;
    logic [15:0]        w;
    logic [15:0]        g;
    logic [15:0]        h;
  } sband_t;

endpackage

`default_nettype wire

@@ src/current_set_drift_solver_top.sv @@
`default_nettype none

// Set and drift solver: each input word carries water speed, heading, ground speed and
// track, and one output word with the current's speed and direction follows it.
// A new word is taken in every cycle unless an output word waits; all stages move
// together and hold while it waits, the length being set by the sine/cosine
// rotation, the sixteen-step arctangent and the thirty-two-step square root.
module current_set_drift_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // water_speed, heading, ground_speed, track
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // current_speed, current_angle, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N = csds_pkg::CORDIC_STAGES;
  localparam int SQ = csds_pkg::SQRT_STEPS;
  localparam int AL = SQ + 2;
  localparam int CS_ST = N + 3;
  localparam int MUL_ST = N + 4;
  localparam int FIN_ST = N + 8 + SQ;
  localparam int NST = FIN_ST + 2;

  localparam logic signed [17:0] FT18 = 18'(csds_pkg::FULL_TURN);
  localparam logic signed [17:0] HT18 = 18'(csds_pkg::HALF_TURN);
  localparam logic signed [16:0] FT17 = 17'(csds_pkg::FULL_TURN);
  localparam logic signed [18:0] FT19 = 19'(csds_pkg::FULL_TURN);
  localparam logic signed [18:0] HT19 = 19'(csds_pkg::HALF_TURN);
  localparam logic signed [18:0] QT19 = 19'(csds_pkg::QUARTER_TURN);
  localparam logic signed [32:0] GAIN33 = 33'(csds_pkg::CORDIC_GAIN);
  localparam logic signed [49:0] GRD_RND = 50'(64'd1 << (csds_pkg::GUARD_SHIFT - 1));
  localparam logic signed [50:0] ANG_RND = 51'(64'd1 << 31);
  localparam int A0_W = 32 - csds_pkg::RECIP_SHIFT;

  logic [15:0] spd_tol_r, ang_tol_r;
  logic        en;
  logic [NST-1:0] vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_tol_r <= csds_pkg::SPEED_TOL_RST;
      ang_tol_r <= csds_pkg::ANGLE_TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csds_pkg::REG_SPEED_TOL: spd_tol_r <= cfg_data;
        csds_pkg::REG_ANGLE_TOL: ang_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !vld_r[NST-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Input stage: classify the word and reduce the drift into one turn.
  logic [15:0] wi, hi, gi, ti;
  logic signed [17:0] d, dd, ad, add, m1, m2;
  csds_pkg::sband_t sb0_nxt;
  csds_pkg::sband_t sb_r [FIN_ST+1];
  logic [15:0] s0_m_r;

  assign wi = in_tdata[15:0];
  assign hi = in_tdata[31:16];
  assign gi = in_tdata[47:32];
  assign ti = in_tdata[63:48];

  always_comb begin
    d = $signed({2'b00, ti}) - $signed({2'b00, hi});
    dd = d - HT18;
    ad = (d < 0) ? -d : d;
    add = (dd < 0) ? -dd : dd;
    sb0_nxt.w = wi;
    sb0_nxt.g = gi;
    sb0_nxt.h = hi;
    sb0_nxt.spec = 1'b1;
    if (gi < spd_tol_r) begin
      sb0_nxt.ang = $signed({2'b00, hi}) - HT18;
      sb0_nxt.spd = $signed({2'b00, wi});
    end else if (wi < spd_tol_r) begin
      sb0_nxt.ang = $signed({2'b00, hi});
      sb0_nxt.spd = $signed({2'b00, gi});
    end else if ($unsigned(ad) < {2'b00, ang_tol_r}) begin
      sb0_nxt.ang = $signed({2'b00, ti});
      sb0_nxt.spd = $signed({2'b00, gi}) - $signed({2'b00, wi});
    end else if ($unsigned(add) < {2'b00, ang_tol_r}) begin
      sb0_nxt.ang = $signed({2'b00, hi}) - HT18;
      sb0_nxt.spd = $signed({2'b00, gi}) + $signed({2'b00, wi});
    end else begin
      sb0_nxt.spec = 1'b0;
      sb0_nxt.ang = '0;
      sb0_nxt.spd = '0;
    end
    if (d < 0) begin
      m1 = d + FT18;
    end else if (d >= FT18) begin
      m1 = d - FT18;
    end else begin
      m1 = d;
    end
    m2 = (m1 < 0) ? m1 + FT18 : m1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_m_r <= m2[15:0];
      sb_r[0] <= sb0_nxt;
    end
  end

  for (genvar k = 1; k <= FIN_ST; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // Split the reduced drift into quotient and remainder by PHASE_DIV (1/512 of a turn).
  logic [31:0] s1_prod;
  logic [A0_W-1:0] s1_a0;
  logic [16:0] s1_rem;
  logic [csds_pkg::PH_A_W-1:0] s1_a_r;
  logic [csds_pkg::PH_B_W-1:0] s1_b_r;

  assign s1_prod = {16'd0, s0_m_r} * 32'(csds_pkg::RECIP_MUL);
  assign s1_a0 = s1_prod[31:csds_pkg::RECIP_SHIFT];
  assign s1_rem = {1'b0, s0_m_r} - 17'(s1_a0 * csds_pkg::PHASE_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_rem >= 17'(csds_pkg::PHASE_DIV)) begin
        s1_a_r <= csds_pkg::PH_A_W'(s1_a0 + 1'b1);
        s1_b_r <= csds_pkg::PH_B_W'(s1_rem - 17'(csds_pkg::PHASE_DIV));
      end else begin
        s1_a_r <= csds_pkg::PH_A_W'(s1_a0);
        s1_b_r <= csds_pkg::PH_B_W'(s1_rem);
      end
    end
  end

  // Phase word and half-turn fold.
  logic [31:0] s2_p, s2_pp;
  logic s2_flip_nxt;
  logic signed [33:0] s2_z_r;
  logic s2_flip_r;

  assign s2_p = {s1_a_r, csds_pkg::PH_SHIFT'(0)}
              + {csds_pkg::PH_A_W'(0), csds_pkg::PFRAC_TAB[s1_b_r]};
  assign s2_flip_nxt = (s2_p > 32'h4000_0000) && (s2_p < 32'hC000_0000);
  assign s2_pp = s2_flip_nxt ? s2_p - 32'h8000_0000 : s2_p;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_z_r <= $signed({{2{s2_pp[31]}}, s2_pp});
      s2_flip_r <= s2_flip_nxt;
    end
  end

  // Rotation for cosine and sine, one iteration per stage.
  logic signed [32:0] rx_r [N];
  logic signed [32:0] ry_r [N];
  logic signed [33:0] rz_r [N];
  logic               rf_r [N];

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [32:0] xi, yi, xsh, ysh;
    logic signed [33:0] zi, ai;
    logic fi;
    if (i == 0) begin : g_first
      assign xi = GAIN33;
      assign yi = '0;
      assign zi = s2_z_r;
      assign fi = s2_flip_r;
    end else begin : g_next
      assign xi = rx_r[i-1];
      assign yi = ry_r[i-1];
      assign zi = rz_r[i-1];
      assign fi = rf_r[i-1];
    end
    assign xsh = xi >>> i;
    assign ysh = yi >>> i;
    assign ai = $signed({2'b00, csds_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rf_r[i] <= fi;
        if (zi >= 0) begin
          rx_r[i] <= xi - ysh;
          ry_r[i] <= yi + xsh;
          rz_r[i] <= zi - ai;
        end else begin
          rx_r[i] <= xi + ysh;
          ry_r[i] <= yi - xsh;
          rz_r[i] <= zi + ai;
        end
      end
    end
  end

  // Vector triangle in the drift frame.
  logic signed [32:0] cs_c_r, cs_s_r;
  logic signed [49:0] mul_gc_r, mul_gs_r;
  logic signed [49:0] xy_xsum, xy_ysum;
  logic signed [33:0] xy_xs, xy_ys;
  logic [31:0] xy_ax_r;
  logic signed [31:0] xy_ys_r;
  logic [31:0] sq_ay;
  logic [63:0] sq_x_r, sq_y_r;
  logic [63:0] sum_r;
  logic sum_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cs_c_r <= rf_r[N-1] ? -rx_r[N-1] : rx_r[N-1];
      cs_s_r <= rf_r[N-1] ? -ry_r[N-1] : ry_r[N-1];
      mul_gc_r <= $signed({1'b0, sb_r[CS_ST].g}) * cs_c_r;
      mul_gs_r <= $signed({1'b0, sb_r[CS_ST].g}) * cs_s_r;
    end
  end

  assign xy_xsum = mul_gc_r - $signed({4'd0, sb_r[MUL_ST].w, 30'd0}) + GRD_RND;
  assign xy_ysum = mul_gs_r + GRD_RND;
  assign xy_xs = xy_xsum[49:csds_pkg::GUARD_SHIFT];
  assign xy_ys = xy_ysum[49:csds_pkg::GUARD_SHIFT];
  assign sq_ay = 32'((xy_ys_r < 0) ? -xy_ys_r : xy_ys_r);

  always_ff @(posedge clk) begin
    if (en) begin
      xy_ax_r <= 32'((xy_xs < 0) ? -xy_xs : xy_xs);
      xy_ys_r <= xy_ys[31:0];
      sq_x_r <= xy_ax_r * xy_ax_r;
      sq_y_r <= sq_ay * sq_ay;
      sum_r <= sq_x_r + sq_y_r;
      sum_zero_r <= (sq_x_r + sq_y_r) == 64'd0;
    end
  end

  // Arctangent by vectoring; later stages only carry the values along unchanged.
  logic signed [33:0] vx_r [AL];
  logic signed [33:0] vy_r [AL];
  logic signed [33:0] vz_r [AL];

  for (genvar i = 0; i < AL; i++) begin : g_vec
    logic signed [33:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = $signed({2'b00, xy_ax_r});
      assign yi = $signed({{2{xy_ys_r[31]}}, xy_ys_r});
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_r[i-1];
      assign yi = vy_r[i-1];
      assign zi = vz_r[i-1];
    end
    if (i < N) begin : g_step
      logic signed [33:0] xsh, ysh, ai;
      assign xsh = xi >>> i;
      assign ysh = yi >>> i;
      assign ai = $signed({2'b00, csds_pkg::ATAN_TAB[i]});
      always_ff @(posedge clk) begin
        if (en) begin
          if (yi > 0) begin
            vx_r[i] <= xi + ysh;
            vy_r[i] <= yi - xsh;
            vz_r[i] <= zi + ai;
          end else if (yi < 0) begin
            vx_r[i] <= xi - ysh;
            vy_r[i] <= yi + xsh;
            vz_r[i] <= zi - ai;
          end else begin
            vx_r[i] <= xi;
            vy_r[i] <= yi;
            vz_r[i] <= zi;
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          vx_r[i] <= xi;
          vy_r[i] <= yi;
          vz_r[i] <= zi;
        end
      end
    end
  end

  // Square root, one result bit per stage.
  logic [63:0] qn_r [SQ];
  logic [63:0] qr_r [SQ];
  logic        qz_r [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (2 * (SQ - 1 - j));
    logic [63:0] ni, ri;
    logic [64:0] rb;
    logic zi;
    if (j == 0) begin : g_first
      assign ni = sum_r;
      assign ri = '0;
      assign zi = sum_zero_r;
    end else begin : g_next
      assign ni = qn_r[j-1];
      assign ri = qr_r[j-1];
      assign zi = qz_r[j-1];
    end
    assign rb = {1'b0, ri} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        qz_r[j] <= zi;
        if ({1'b0, ni} >= rb) begin
          qn_r[j] <= ni - rb[63:0];
          qr_r[j] <= (ri >> 1) + BIT;
        end else begin
          qn_r[j] <= ni;
          qr_r[j] <= ri >> 1;
        end
      end
    end
  end

  // Rounding of speed and angle, with the speed clamped to SPEED_MAX.
  logic [63:0] fin_rnd;
  logic [63:0] fin_spd;
  logic signed [50:0] fin_za;
  logic [17:0] fin_spd_r;
  logic signed [18:0] fin_a_r;
  logic fin_zero_r;

  assign fin_rnd = qr_r[SQ-1] + (64'd1 << (csds_pkg::KEEP_BITS - 1));
  assign fin_spd = fin_rnd >> csds_pkg::KEEP_BITS;
  assign fin_za = vz_r[AL-1] * FT17 + ANG_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_spd_r <= (fin_spd > 64'(csds_pkg::SPEED_MAX)) ? 18'(csds_pkg::SPEED_MAX)
                                                          : fin_spd[17:0];
      fin_a_r <= fin_za[50:32];
      fin_zero_r <= qz_r[SQ-1];
    end
  end

  // Output word: select the rule and wrap the angle once.
  logic signed [18:0] out_pre, out_w1, out_w2;
  logic [17:0] out_spd_r;
  logic [15:0] out_ang_r;
  csds_pkg::sband_t sbf;

  assign sbf = sb_r[FIN_ST];

  always_comb begin
    if (sbf.spec) begin
      out_pre = {sbf.ang[17], sbf.ang};
    end else if (fin_zero_r) begin
      out_pre = QT19 + $signed({3'b000, sbf.h});
    end else begin
      out_pre = HT19 - fin_a_r + $signed({3'b000, sbf.h});
    end
    out_w1 = (out_pre < 0) ? out_pre + FT19 : out_pre;
    out_w2 = (out_w1 >= FT19) ? out_w1 - FT19 : out_w1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_spd_r <= sbf.spec ? sbf.spd : fin_spd_r;
      out_ang_r <= out_w2[15:0];
    end
  end

  assign out_tdata = {6'd0, out_ang_r, out_spd_r};

endmodule

`default_nettype wire

@@ src/csds_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module csds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `CSDS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output word changed")
  `CSDS_ASSERT(a_in_stall, out_tvalid && !out_tready |-> !in_tready, "input taken while output blocked")
  `CSDS_ASSERT(a_out_pad, out_tvalid |-> out_tdata[39:34] == 6'd0, "output fill bits not zero")
  `CSDS_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")
  `CSDS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind current_set_drift_solver_top csds_checker u_csds_checker (.*);

`default_nettype wire
